@@ sv/pli_pkg.sv @@
// ---------------------------------------------------------------------------
// pli_pkg: shared types and constants of the piecewise linear interpolator
// Breakpoint table sizing, datapath widths, request types and status codes.
// ---------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

	// table sizing
	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	// datapath widths: Q16.16 values, differences, product, remainder, sum
	localparam int XW = 32;
	localparam int DW = XW + 1;
	localparam int PW = 2 * DW;
	localparam int RW = DW + 1;
	localparam int SW = PW + 2;

	// bit-serial unit lengths
	localparam int MUL_STEPS = DW;
	localparam int DIV_STEPS = PW;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// front queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// status codes
	localparam logic [2:0] ST_ADDED = 3'd0;
	localparam logic [2:0] ST_DUP   = 3'd1;
	localparam logic [2:0] ST_FULL  = 3'd2;
	localparam logic [2:0] ST_OK    = 3'd3;
	localparam logic [2:0] ST_FEW   = 3'd4;
	localparam logic [2:0] ST_SAT   = 3'd5;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	typedef struct packed {
		logic                 command;
		logic signed [XW-1:0] x_value;
		logic signed [XW-1:0] y_value;
	} req_t;

	typedef struct packed {
		logic signed [XW-1:0] result_value;
		logic [2:0]           status;
	} rsp_t;

	typedef enum logic {
		OP_ADD,
		OP_EVAL
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
	} job_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_RDHI,
		S_RDLO,
		S_PREP,
		S_MUL,
		S_DIV,
		S_FIN,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

@@ sv/pli_ram.sv @@
// ---------------------------------------------------------------------------
// pli_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module pli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ sv/pli_front.sv @@
// ---------------------------------------------------------------------------
// pli_front: request intake and classification
// Decodes each request into a job and holds it in a short queue for the back.
// ---------------------------------------------------------------------------
`default_nettype none

module pli_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire pli_pkg::req_t req,
	output logic               job_valid,
	output pli_pkg::job_t      job,
	input  wire logic          job_pop
);
	import pli_pkg::*;

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	job_t              incoming;

	// classify the request
	always_comb begin
		incoming.op = (req.command == CMD_ADD) ? OP_ADD : OP_EVAL;
		incoming.x  = req.x_value;
		incoming.y  = req.y_value;
	end

	assign req_stall = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push      = req_valid && !req_stall;
	assign job_valid = (count_q != '0);
	assign job       = slot_q[rd_ptr_q];

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (job_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !job_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && job_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= incoming;
		end
	end

endmodule

`default_nettype wire

@@ sv/pli_back.sv @@
// ---------------------------------------------------------------------------
// pli_back: breakpoint table and evaluation engine
// Scans the x table, stores points, then runs a bit-serial multiply and a
// restoring divide to interpolate; holds the response in an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module pli_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	input  wire pli_pkg::job_t job,
	output logic               job_pop,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output pli_pkg::rsp_t      rsp
);
	import pli_pkg::*;

	state_t state_q, state_d;

	job_t             job_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] iss_q;
	logic             cmp_valid_s1;
	logic [IDX_W-1:0] cmp_idx_s1;

	// scan trackers
	logic                 dup_q;
	logic                 has_lo_q, has_hi_q, has_mn1_q, has_mn2_q, has_mx1_q, has_mx2_q;
	logic signed [XW-1:0] lo_x_q, hi_x_q, mn1_x_q, mn2_x_q, mx1_x_q, mx2_x_q;
	logic [IDX_W-1:0]     lo_i_q, hi_i_q, mn1_i_q, mn2_i_q, mx1_i_q, mx2_i_q;

	// chosen points: a = second point (the lower one when bracketed), b = anchor
	logic signed [XW-1:0] xa_q, xb_q, yb_q;
	logic [IDX_W-1:0]     ia_q, ib_q;

	// arithmetic
	logic [DW-1:0]     mcand_q;
	logic [DW-1:0]     dd_q;
	logic [PW-1:0]     prod_q;
	logic [RW-1:0]     rem_q;
	logic              neg_q;
	logic [STEP_W-1:0] step_q;

	logic signed [XW-1:0] res_q;
	logic [2:0]           status_q;
	logic                 out_valid_q;
	rsp_t                 out_q;

	// control outputs
	logic             rd_en, we, out_free;
	logic [IDX_W-1:0] x_raddr, y_raddr, waddr;

	logic [XW-1:0] x_rdata, y_rdata;

	pli_ram #(.WIDTH(XW), .DEPTH(MAX_POINTS)) u_x_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (job_q.x),
		.raddr (x_raddr),
		.rdata (x_rdata)
	);

	pli_ram #(.WIDTH(XW), .DEPTH(MAX_POINTS)) u_y_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (job_q.y),
		.raddr (y_raddr),
		.rdata (y_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (job_valid) begin
					if (job.op == OP_EVAL && cnt_q < CNT_W'(2)) begin
						state_d = S_DONE;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (iss_q == cnt_q && !cmp_valid_s1) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: state_d = (job_q.op == OP_ADD) ? S_DONE : S_RDHI;
			S_RDHI:   state_d = S_RDLO;
			S_RDLO:   state_d = S_PREP;
			S_PREP:   state_d = S_MUL;
			S_MUL: begin
				if (step_q == STEP_W'(MUL_STEPS - 1)) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = S_FIN;
				end
			end
			S_FIN: state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		job_pop  = (state_q == S_IDLE) && job_valid;
		rd_en    = (state_q == S_SCAN) && (iss_q < cnt_q);
		x_raddr  = iss_q[IDX_W-1:0];
		y_raddr  = (state_q == S_RDHI) ? ib_q : ia_q;
		we       = (state_q == S_DECIDE) && (job_q.op == OP_ADD) && !dup_q &&
		           (cnt_q < CNT_W'(MAX_POINTS));
		waddr    = cnt_q[IDX_W-1:0];
		out_free = !out_valid_q || !rsp_stall;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			cmp_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			cmp_valid_s1 <= rd_en;
			if (we) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// scan compare stage
	logic signed [XW-1:0] v;
	logic                 v_le;
	assign v    = signed'(x_rdata);
	assign v_le = (v <= job_q.x);

	// arithmetic helpers
	logic signed [DW-1:0] dx, dy, dd;
	logic [RW-1:0]        mul_sum;
	logic [RW-1:0]        r_sh;
	logic                 q_bit;
	logic signed [SW-1:0] ext_y, ext_q, sum;

	always_comb begin
		dx = DW'(job_q.x) - DW'(xb_q);
		dy = DW'(signed'(y_rdata)) - DW'(yb_q);
		dd = DW'(xa_q) - DW'(xb_q);
		mul_sum = {1'b0, prod_q[PW-1:DW]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
		r_sh    = {rem_q[RW-2:0], prod_q[PW-1]};
		q_bit   = (r_sh >= {1'b0, dd_q});
		ext_y   = SW'(yb_q);
		ext_q   = {2'b00, prod_q};
		sum     = neg_q ? (ext_y - ext_q) : (ext_y + ext_q);
	end

	// datapath registers
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= x_raddr;
		case (state_q)
			S_IDLE: begin
				if (job_valid) begin
					job_q     <= job;
					iss_q     <= '0;
					dup_q     <= 1'b0;
					has_lo_q  <= 1'b0;
					has_hi_q  <= 1'b0;
					has_mn1_q <= 1'b0;
					has_mn2_q <= 1'b0;
					has_mx1_q <= 1'b0;
					has_mx2_q <= 1'b0;
					res_q     <= '0;
					status_q  <= ST_FEW;
				end
			end
			S_SCAN: begin
				if (rd_en) begin
					iss_q <= iss_q + 1'b1;
				end
				if (cmp_valid_s1) begin
					if (v == job_q.x) begin
						dup_q <= 1'b1;
					end
					// nearest neighbours of the query
					if (v_le && (!has_lo_q || v > lo_x_q)) begin
						has_lo_q <= 1'b1;
						lo_x_q   <= v;
						lo_i_q   <= cmp_idx_s1;
					end
					if (!v_le && (!has_hi_q || v < hi_x_q)) begin
						has_hi_q <= 1'b1;
						hi_x_q   <= v;
						hi_i_q   <= cmp_idx_s1;
					end
					// two smallest
					if (!has_mn1_q || v < mn1_x_q) begin
						has_mn1_q <= 1'b1;
						mn1_x_q   <= v;
						mn1_i_q   <= cmp_idx_s1;
						has_mn2_q <= has_mn1_q;
						mn2_x_q   <= mn1_x_q;
						mn2_i_q   <= mn1_i_q;
					end else if (!has_mn2_q || v < mn2_x_q) begin
						has_mn2_q <= 1'b1;
						mn2_x_q   <= v;
						mn2_i_q   <= cmp_idx_s1;
					end
					// two largest
					if (!has_mx1_q || v > mx1_x_q) begin
						has_mx1_q <= 1'b1;
						mx1_x_q   <= v;
						mx1_i_q   <= cmp_idx_s1;
						has_mx2_q <= has_mx1_q;
						mx2_x_q   <= mx1_x_q;
						mx2_i_q   <= mx1_i_q;
					end else if (!has_mx2_q || v > mx2_x_q) begin
						has_mx2_q <= 1'b1;
						mx2_x_q   <= v;
						mx2_i_q   <= cmp_idx_s1;
					end
				end
			end
			S_DECIDE: begin
				res_q <= '0;
				if (job_q.op == OP_ADD) begin
					if (dup_q) begin
						status_q <= ST_DUP;
					end else if (cnt_q >= CNT_W'(MAX_POINTS)) begin
						status_q <= ST_FULL;
					end else begin
						status_q <= ST_ADDED;
					end
				end else if (!has_lo_q) begin
					// below all points: smallest is the anchor
					xa_q <= mn2_x_q;
					ia_q <= mn2_i_q;
					xb_q <= mn1_x_q;
					ib_q <= mn1_i_q;
				end else if (!has_hi_q) begin
					// at or above all points: second largest is the anchor
					xa_q <= mx1_x_q;
					ia_q <= mx1_i_q;
					xb_q <= mx2_x_q;
					ib_q <= mx2_i_q;
				end else begin
					xa_q <= lo_x_q;
					ia_q <= lo_i_q;
					xb_q <= hi_x_q;
					ib_q <= hi_i_q;
				end
			end
			S_RDLO: begin
				yb_q <= signed'(y_rdata);
			end
			S_PREP: begin
				mcand_q <= dx[DW-1] ? DW'(-dx) : DW'(dx);
				prod_q  <= {{DW{1'b0}}, (dy[DW-1] ? DW'(-dy) : DW'(dy))};
				dd_q    <= dd[DW-1] ? DW'(-dd) : DW'(dd);
				neg_q   <= dx[DW-1] ^ dy[DW-1] ^ dd[DW-1];
				step_q  <= '0;
			end
			S_MUL: begin
				prod_q <= {mul_sum, prod_q[DW-1:1]};
				if (step_q == STEP_W'(MUL_STEPS - 1)) begin
					step_q <= '0;
					rem_q  <= '0;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
			S_DIV: begin
				rem_q  <= q_bit ? (r_sh - {1'b0, dd_q}) : r_sh;
				prod_q <= {prod_q[PW-2:0], q_bit};
				step_q <= step_q + 1'b1;
			end
			S_FIN: begin
				// clamp to the signed 32-bit range
				if (sum > SW'(64'sh7FFF_FFFF)) begin
					res_q    <= {1'b0, {(XW-1){1'b1}}};
					status_q <= ST_SAT;
				end else if (sum < -SW'(64'sh8000_0000)) begin
					res_q    <= {1'b1, {(XW-1){1'b0}}};
					status_q <= ST_SAT;
				end else begin
					res_q    <= sum[XW-1:0];
					status_q <= ST_OK;
				end
			end
			default: begin
			end
		endcase
		if (state_q == S_DONE && out_free) begin
			out_q.result_value <= res_q;
			out_q.status       <= status_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

`default_nettype wire

@@ sv/piecewise_linear_interpolator_top.sv @@
// ---------------------------------------------------------------------------
// piecewise_linear_interpolator_top: Q16.16 breakpoint table interpolator
// Adds breakpoints and evaluates the piecewise linear curve through them.
// ---------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  req      in   req_valid / req_stall   req_t  (command, x_value, y_value)
//  rsp      out  rsp_valid / rsp_stall   rsp_t  (result_value, status)
//
//  An add scans the stored points for duplicates through the one read
//  port of the x table. An evaluate runs the scan, two y-table reads, a
//  set-up step, a 33-step shift-add multiply and a 66-step restoring divide.
//  An evaluate on too few points goes straight to its response.
//  A 2-entry queue takes requests while the back is busy; reset empties the
//  table and the queue. A stalled response holds the back in its last state
//  until taken.
// ---------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_interpolator_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire pli_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output pli_pkg::rsp_t      rsp
);
	import pli_pkg::*;

	logic job_valid;
	job_t job;
	logic job_pop;

	pli_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop)
	);

	pli_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// the back only takes a job that is queued
	a_pop_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid)
		else $error("job popped from an empty queue");

	// a queued job stays until the back takes it
	a_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && !job_pop |=> job_valid)
		else $error("queued job lost");

	// responses without a value carry zero
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_ADDED || rsp.status == ST_DUP ||
		rsp.status == ST_FULL || rsp.status == ST_FEW) |-> rsp.result_value == '0)
		else $error("non-zero result on a response without a value");

	// saturation gives a range limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_SAT |->
		(rsp.result_value == 32'sh7FFF_FFFF || rsp.result_value == 32'sh8000_0000))
		else $error("saturated response not at a range limit");

endmodule

`default_nettype wire

@@ test/pli_checker.sv @@
// ---------------------------------------------------------------------------
// pli_checker: response checker for the piecewise linear interpolator
// Watches both channels, keeps its own copy of the breakpoint table, works
// out the response of every accepted request and compares it in order.
// ---------------------------------------------------------------------------
`default_nettype none

module pli_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic          req_stall,
	input  wire pli_pkg::req_t req,
	input  wire logic          rsp_valid,
	input  wire logic          rsp_stall,
	input  wire pli_pkg::rsp_t rsp,
	output int                 fail_count,
	output int                 outstanding
);
	import pli_pkg::*;

	localparam longint QUOT_CAP = 64'd1 << 40;

	// mirrored breakpoint table
	longint    bp_x [MAX_POINTS];
	longint    bp_y [MAX_POINTS];
	int        bp_n;
	rsp_t      expected_rsp [$];

	// predicted response: a table add, or a line through the bracketing pair, anchored at the upper point
	function automatic rsp_t interpolate(req_t r);
		rsp_t         o;
		longint       xq, v, dx, dy, dd, sv, res;
		int           lo, hi;
		bit           has_lo, has_hi, neg;
		logic [127:0] mag;
		o.result_value = '0;
		o.status = ST_OK;
		xq = longint'(r.x_value);
		lo = 0;
		hi = 0;
		has_lo = 0;
		has_hi = 0;
		if (r.command == CMD_ADD) begin
			for (int i = 0; i < bp_n; i++)
				if (bp_x[i] == xq) begin
					o.status = ST_DUP;
					return o;
				end
			if (bp_n >= MAX_POINTS) begin
				o.status = ST_FULL;
				return o;
			end
			bp_x[bp_n] = xq;
			bp_y[bp_n] = longint'(r.y_value);
			bp_n++;
			o.status = ST_ADDED;
			return o;
		end
		if (bp_n < 2) begin
			o.status = ST_FEW;
			return o;
		end
		for (int i = 0; i < bp_n; i++) begin
			v = bp_x[i];
			if (v <= xq && (!has_lo || v > bp_x[lo])) begin lo = i; has_lo = 1; end
			if (v > xq && (!has_hi || v < bp_x[hi])) begin hi = i; has_hi = 1; end
		end
		// below the table: second smallest becomes the lower point
		if (!has_lo)
			for (int i = 0; i < bp_n; i++) begin
				v = bp_x[i];
				if (v > bp_x[hi] && (!has_lo || v < bp_x[lo])) begin lo = i; has_lo = 1; end
			end
		// at or above the table: second largest becomes the upper point
		if (!has_hi)
			for (int i = 0; i < bp_n; i++) begin
				v = bp_x[i];
				if (v < bp_x[lo] && (!has_hi || v > bp_x[hi])) begin hi = i; has_hi = 1; end
			end
		dx = xq - bp_x[hi];
		dy = bp_y[lo] - bp_y[hi];
		dd = bp_x[lo] - bp_x[hi];
		neg = ((dx < 0) != (dy < 0)) != (dd < 0);
		if (dx == 0 || dy == 0)
			neg = 0;
		mag = (128'(dx < 0 ? -dx : dx) * 128'(dy < 0 ? -dy : dy)) / 128'(dd < 0 ? -dd : dd);
		if (mag > 128'(QUOT_CAP))
			mag = 128'(QUOT_CAP);
		sv = longint'(mag[63:0]);
		res = (neg ? -sv : sv) + bp_y[hi];
		if (res > 64'sd2147483647) begin
			res = 64'sd2147483647;
			o.status = ST_SAT;
		end
		if (res < -64'sd2147483648) begin
			res = -64'sd2147483648;
			o.status = ST_SAT;
		end
		o.result_value = res[31:0];
		return o;
	endfunction

	assign outstanding = expected_rsp.size();

	initial begin
		fail_count = 0;
		bp_n = 0;
	end

	// predict on each accepted request, compare on each accepted response
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: unexpected response value=%h status=%0d",
						$time, rsp.result_value, rsp.status);
					fail_count++;
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.result_value !== want.result_value) begin
						$display("%0t: result_value expected %h actual %h",
							$time, want.result_value, rsp.result_value);
						fail_count++;
					end
					if (rsp.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp.status);
						fail_count++;
					end
				end
			end
			if (req_valid && !req_stall)
				expected_rsp.push_back(interpolate(req));
		end
	end

endmodule

`default_nettype wire

@@ test/tb.sv @@
// ---------------------------------------------------------------------------
// tb: testbench top for the piecewise linear interpolator
// Directed breakpoint and query requests, then random traffic that fills
// the table with duplicates and extremes mixed in, with random gaps on the
// request side and random stalls on the response side.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
	import pli_pkg::*;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	int   fail_count;
	int   outstanding;
	bit   no_idle;
	int   rsp_hold;
	bit   rsp_taken;
	logic signed [31:0] added_x [$];

	piecewise_linear_interpolator_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	pli_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial clk = 0;
	always #6 clk = ~clk;

	// hard stop
	initial begin
		#30000000;
		$display("Regression FAIL");
		$finish;
	end

	// response side: stall for a random count after each taken response
	initial begin
		rsp_stall = 1;
		rsp_hold = $urandom_range(19);
		rsp_taken = 0;
	end
	always @(posedge clk)
		if (rsp_valid && !rsp_stall)
			rsp_taken <= 1;
	always @(negedge clk) begin
		if (rsp_taken) begin
			rsp_taken <= 0;
			rsp_hold = no_idle ? 0 : $urandom_range(19);
		end
		if (rsp_hold > 0) begin
			rsp_stall <= 1;
			rsp_hold--;
		end else
			rsp_stall <= 0;
	end

	// one request, entered just after a falling edge
	task automatic send(logic cmd, logic [31:0] x, logic [31:0] y);
		int gap;
		gap = no_idle ? 0 : $urandom_range(19);
		if (gap > 0) begin
			req_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1;
		req <= '{command: cmd, x_value: x, y_value: y};
		if (cmd == CMD_ADD)
			added_x.push_back(x);
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	// operand mix: full range, small Q16.16, extremes, near a stored x
	function automatic logic [31:0] pick_value(bit near_ok);
		int k;
		logic [31:0] base;
		k = $urandom_range(9);
		if (near_ok && added_x.size() > 0 && k < 4) begin
			base = added_x[$urandom_range(added_x.size() - 1)];
			return base + 32'($signed($urandom_range(6)) - 3);
		end
		case (k)
			4, 5:    return $urandom;
			6:       return 32'($signed($urandom_range(64)) - 32) <<< 16;
			7:       return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			8:       return 32'($signed($urandom_range(8)) - 4);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		bit cmd;
		arst_n = 0;
		req_valid = 0;
		req = '0;
		no_idle = 0;
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: empty and single-point table, duplicates, extremes
		send(CMD_EVAL, 32'h0, 32'h0);
		send(CMD_ADD, 32'h0, 32'h0);
		send(CMD_EVAL, 32'h0, 32'hffffffff);
		send(CMD_ADD, 32'h0, 32'h00050000);
		send(CMD_ADD, 32'h7fffffff, 32'h7fffffff);
		send(CMD_EVAL, 32'h0, 32'h0);
		send(CMD_EVAL, 32'h80000000, 32'h0);
		send(CMD_EVAL, 32'h7fffffff, 32'h0);
		send(CMD_EVAL, 32'h40000000, 32'h0);
		send(CMD_ADD, 32'h80000000, 32'h80000000);
		send(CMD_EVAL, 32'h80000000, 32'h0);
		send(CMD_EVAL, 32'h7fffffff, 32'h0);
		send(CMD_EVAL, 32'hffffffff, 32'h0);
		send(CMD_ADD, 32'h00000001, 32'h80000000);
		send(CMD_EVAL, 32'h00010000, 32'h0);
		send(CMD_EVAL, 32'h7ffffffe, 32'h0);
		send(CMD_ADD, 32'h00000002, 32'h7fffffff);
		send(CMD_EVAL, 32'h3fffffff, 32'h0);
		send(CMD_EVAL, 32'hc0000000, 32'h0);
		send(CMD_ADD, 32'hffffffff, 32'h0);
		send(CMD_ADD, 32'h80000000, 32'h12345678);

		// random: adds make up close to half until 90 adds are sent, then mostly queries
		for (int n = 0; n < 1700; n++) begin
			no_idle = (n / 150) % 4 == 3;
			if (added_x.size() < 90)
				cmd = $urandom_range(99) < 55 ? CMD_EVAL : CMD_ADD;
			else
				cmd = $urandom_range(99) < 88 ? CMD_EVAL : CMD_ADD;
			send(cmd, pick_value(1), pick_value(0));
		end
		req_valid <= 0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
